FILE: rtl/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
package swm_pkg;

	localparam int WS_WIDTH = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT,
		ST_MEDIAN
	} state_t;

	typedef struct packed {
		logic capture;
		logic remove;
		logic insert;
		logic load_out;
		logic cfg_write;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic result;
	} status_t;

endpackage

FILE: rtl/sliding_window_median.sv
// Top level of the sliding window median filter.
// Running lower-median filter over the last window_size signed samples. A sample
// that does not yet complete the window passes accept and sorted insert. The
// sample that completes it passes accept, insert and result load. Once the
// window is full every sample passes accept with ring read, removal of the
// oldest sample from the sorted cell row, insert and result load. The result load
// waits for as long as the output is stalled. The sorted cell row, which does one
// shift per cycle, and the registered read of the arrival ring set these steps.
// No result is produced until the window holds window_size samples. Writing
// window_size empties the window, a value of zero acts as one, and a value above
// MAX_WINDOW acts as MAX_WINDOW.
module sliding_window_median #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] median_value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [swm_pkg::WS_WIDTH-1:0]   window_size
);

	import swm_pkg::*;

	cmd_t    cmd;
	status_t status;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	swm_datapath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_value (sample_value),
		.window_size  (window_size),
		.cmd          (cmd),
		.status       (status),
		.median_value (median_value)
	);

endmodule

FILE: rtl/swm_ram.sv
// Generic single write port, single read port RAM with registered read data.
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [ADDR_WIDTH-1:0] waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [ADDR_WIDTH-1:0] raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/swm_ctrl.sv
// Controller state machine that sequences each sample through the datapath.
module swm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  swm_pkg::status_t status,
	output swm_pkg::cmd_t    cmd
);

	import swm_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = status.full ? ST_REMOVE : ST_INSERT;
				end
			end
			ST_REMOVE: begin
				state_nxt = ST_INSERT;
			end
			ST_INSERT: begin
				state_nxt = status.result ? ST_MEDIAN : ST_IDLE;
			end
			ST_MEDIAN: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cfg_ready     = 1'b1;
				cmd.capture   = in_valid;
				cmd.cfg_write = cfg_valid;
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
			end
			ST_MEDIAN: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/swm_datapath.sv
// Datapath: arrival ring, sorted cell row, window counters and result register.
module swm_datapath #(
	parameter int MAX_WINDOW   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample_value,
	input  logic [swm_pkg::WS_WIDTH-1:0]    window_size,
	input  swm_pkg::cmd_t                   cmd,
	output swm_pkg::status_t                status,
	output logic signed [SAMPLE_WIDTH-1:0]  median_value
);

	import swm_pkg::*;

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam logic [CW-1:0] KMAX = CW'(MAX_WINDOW);

	logic signed [SAMPLE_WIDTH-1:0] cell_q [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] cell_nxt [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] old_value;
	logic signed [SAMPLE_WIDTH-1:0] median_sel;
	logic signed [SAMPLE_WIDTH-1:0] median_q;
	logic [CW-1:0]                  k_q;
	logic [CW-1:0]                  k_cfg;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  ins_count;
	logic [CW-1:0]                  mid;
	logic [AW-1:0]                  oldest_q;
	logic [AW-1:0]                  ram_waddr;
	logic                           full_q;
	logic                           oldest_wrap;
	logic [MAX_WINDOW-1:0]          le;
	logic [MAX_WINDOW-1:0]          ge;

	swm_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (MAX_WINDOW),
		.ADDR_WIDTH (AW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.insert),
		.waddr (ram_waddr),
		.wdata (sample_q),
		.raddr (oldest_q),
		.rdata (old_value)
	);

	always_comb begin
		if (window_size == '0) begin
			k_cfg = CW'(1);
		end else if (32'(window_size) > 32'(MAX_WINDOW)) begin
			k_cfg = KMAX;
		end else begin
			k_cfg = CW'(window_size);
		end
	end

	assign ins_count   = full_q ? (k_q - CW'(1)) : count_q;
	assign ram_waddr   = full_q ? oldest_q : count_q[AW-1:0];
	assign oldest_wrap = (CW'(oldest_q) + CW'(1)) == k_q;
	assign mid         = (k_q - CW'(1)) >> 1;

	assign status.full   = (count_q == k_q);
	assign status.result = full_q || ((count_q + CW'(1)) == k_q);

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			le[i] = (CW'(i) < ins_count) && (cell_q[i] <= sample_q);
			ge[i] = (CW'(i) < k_q) && (cell_q[i] >= old_value);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			cell_nxt[i] = cell_q[i];
		end
		if (cmd.remove) begin
			for (int i = 0; i < MAX_WINDOW - 1; i++) begin
				if (ge[i]) begin
					cell_nxt[i] = cell_q[i + 1];
				end
			end
		end else if (cmd.insert) begin
			if (!le[0]) begin
				cell_nxt[0] = sample_q;
			end
			for (int i = 1; i < MAX_WINDOW; i++) begin
				if (!le[i]) begin
					cell_nxt[i] = le[i - 1] ? sample_q : cell_q[i - 1];
				end
			end
		end
	end

	always_comb begin
		median_sel = cell_q[0];
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (CW'(i) == mid) begin
				median_sel = cell_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			cell_q[i] <= cell_nxt[i];
		end
		if (cmd.capture) begin
			sample_q <= sample_value;
		end
		if (cmd.load_out) begin
			median_q <= median_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= CW'(3);
			count_q  <= '0;
			oldest_q <= '0;
			full_q   <= 1'b0;
		end else begin
			if (cmd.cfg_write) begin
				k_q      <= k_cfg;
				count_q  <= '0;
				oldest_q <= '0;
			end
			if (cmd.capture) begin
				full_q <= status.full;
			end
			if (cmd.insert) begin
				if (full_q) begin
					oldest_q <= oldest_wrap ? '0 : (oldest_q + AW'(1));
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	assign median_value = median_q;

endmodule
